// ----- rtl/core/kocnt_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// kocnt_pkg
// Shared types and constants for the keyed occurrence counter.
// ---------------------------------------------------------------------------
package kocnt_pkg;
    localparam int KeyW   = 80;
    localparam int CountW = 32;
    localparam int TopW   = 4;

    localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
    localparam logic [TopW-1:0]   TopReset = 4'd10;

    typedef enum logic {
        MODE_COUNT  = 1'b0,
        MODE_REPORT = 1'b1
    } t_mode;

    // One classified beat handed from the front to the back.
    typedef struct packed {
        logic              is_report;
        logic [KeyW-1:0]   key;
        logic [TopW-1:0]   limit;
    } t_cmd;
endpackage
`default_nettype wire

// ----- rtl/core/kocnt_if.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// kocnt_in_if / kocnt_out_if / kocnt_cfg_if
// Valid-ready channels of the keyed occurrence counter.
// ---------------------------------------------------------------------------
interface kocnt_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [63:0] key_low;
    logic [15:0] key_high;
    modport source (output valid, mode, key_low, key_high, input ready);
    modport sink   (input valid, mode, key_low, key_high, output ready);
endinterface

interface kocnt_out_if;
    logic        valid;
    logic        ready;
    logic        entry_valid;
    logic [3:0]  rank;
    logic [63:0] entry_key_low;
    logic [15:0] entry_key_high;
    logic [31:0] entry_count;
    logic [31:0] grand_total;
    logic        table_overflow;
    logic        last;
    modport source (output valid, entry_valid, rank, entry_key_low, entry_key_high,
                    entry_count, grand_total, table_overflow, last, input ready);
    modport sink   (input valid, entry_valid, rank, entry_key_low, entry_key_high,
                    entry_count, grand_total, table_overflow, last, output ready);
endinterface

interface kocnt_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/kocnt_ram.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// kocnt_ram
// Generic single-port RAM with a registered read.
// ---------------------------------------------------------------------------
module kocnt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Read before write, read data registered.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ----- rtl/core/kocnt_front.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// kocnt_front
// Accepts input beats, classifies them and holds a two-entry command queue.
// ---------------------------------------------------------------------------
module kocnt_front #(
    parameter int TOP_MAX = 10
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    kocnt_in_if.sink             in_ch,
    kocnt_cfg_if.sink            cfg_ch,
    output kocnt_pkg::t_cmd      o_cmd,
    output logic                 o_cmd_valid,
    input  wire logic            i_cmd_take
);
    import kocnt_pkg::*;

    logic [TopW-1:0] r_top;
    t_cmd            r_q [2];
    logic [1:0]      r_cnt;
    logic            r_rd;
    logic            push;
    logic            pop;
    t_cmd            cmd_in;
    logic [TopW-1:0] limit;

    assign cfg_ch.ready = 1'b1;
    assign in_ch.ready  = (r_cnt != 2'd2);
    assign push = in_ch.valid && in_ch.ready;
    assign pop  = i_cmd_take && (r_cnt != 2'd0);

    // Clamp the report length to one through TOP_MAX.
    always_comb begin
        limit = r_top;
        if (limit == '0) begin
            limit = TopW'(1);
        end
        if (32'(limit) > TOP_MAX) begin
            limit = TopW'(TOP_MAX);
        end
        cmd_in.is_report = (t_mode'(in_ch.mode) == MODE_REPORT);
        cmd_in.key       = {in_ch.key_low, in_ch.key_high};
        cmd_in.limit     = limit;
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= TopReset;
        end else if (cfg_ch.valid) begin
            r_top <= cfg_ch.data;
        end
    end

    // Two-entry circular queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
        end else begin
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
            if (pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_rd ^ (r_cnt[0] & ~r_cnt[1])] <= cmd_in;
        end
    end

    assign o_cmd       = r_q[r_rd];
    assign o_cmd_valid = (r_cnt != 2'd0);
endmodule
`default_nettype wire

// ----- rtl/core/kocnt_back.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// kocnt_back
// Executes commands: a serial key search with count update, and a report that
// picks the next highest entry by a full scan per rank.
// ---------------------------------------------------------------------------
module kocnt_back #(
    parameter int TABLE_ENTRIES = 128
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  kocnt_pkg::t_cmd    i_cmd,
    input  wire logic          i_cmd_valid,
    output logic               o_cmd_take,
    kocnt_out_if.source        out_ch
);
    import kocnt_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int NW = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SRCH, S_SRCH_CHK, S_SCAN, S_SCAN_CHK, S_FETCH, S_FETCH_W, S_EMIT
    } t_state;

    t_state            r_state;
    logic [NW-1:0]     r_used;
    logic [CountW-1:0] r_total;
    logic              r_ovf;
    logic [AW-1:0]     r_idx;
    logic [NW-1:0]     r_scan;
    logic [TopW-1:0]   r_rank;
    // Previous pick (count, index) bounds the next one.
    logic [CountW-1:0] r_pc;
    logic [AW-1:0]     r_pi;
    logic              r_have;
    logic [CountW-1:0] r_bc;
    logic [AW-1:0]     r_bi;
    logic              r_bfound;
    logic              r_done;
    logic              r_ov;
    logic              r_oev;
    logic [TopW-1:0]   r_orank;
    logic [KeyW-1:0]   r_okey;
    logic [CountW-1:0] r_ocnt;
    logic [CountW-1:0] r_ototal;
    logic              r_oovf;
    logic              r_olast;

    logic              we;
    logic [AW-1:0]     addr;
    logic [KeyW-1:0]   kd;
    logic [CountW-1:0] cd;
    logic [CountW-1:0] cw;
    logic              eligible;
    logic              better;
    logic              hit;
    logic              at_end;
    logic              out_free;
    logic              load_out;
    logic              finish;

    kocnt_ram #(.WIDTH(KeyW), .DEPTH(TABLE_ENTRIES)) u_key (
        .i_clk(i_clk), .i_we(we), .i_addr(addr), .i_wdata(i_cmd.key), .o_rdata(kd));
    kocnt_ram #(.WIDTH(CountW), .DEPTH(TABLE_ENTRIES)) u_cnt (
        .i_clk(i_clk), .i_we(we), .i_addr(addr), .i_wdata(cw), .o_rdata(cd));

    assign hit      = (kd == i_cmd.key);
    assign at_end   = (r_scan == r_used);
    assign out_free = !r_ov || out_ch.ready;
    assign load_out = (r_state == S_FETCH_W) && out_free;
    assign finish   = ((r_state == S_SRCH_CHK) && (at_end || hit)) ||
                      ((r_state == S_EMIT) && r_olast);

    // Memory port control. The end of the search is tested before a hit, as
    // the read data is stale once every used entry has been compared.
    always_comb begin
        we   = 1'b0;
        addr = r_idx;
        cw   = (cd == CountMax) ? cd : cd + 1'b1;
        if (r_state == S_SRCH_CHK) begin
            if (at_end) begin
                if (r_used != NW'(TABLE_ENTRIES)) begin
                    we   = 1'b1;
                    addr = r_used[AW-1:0];
                    cw   = CountW'(1);
                end
            end else if (hit) begin
                we = 1'b1;
            end
        end
        if (r_state == S_FETCH || r_state == S_FETCH_W) begin
            addr = r_bi;
        end
    end

    // An entry ranks after the previous pick: lower count, or equal and later.
    always_comb begin
        eligible = !r_have || (cd < r_pc) || (cd == r_pc && r_idx > r_pi);
        better   = !r_bfound || (cd > r_bc);
    end

    // The command leaves the queue the cycle after its work has finished.
    assign o_cmd_take = r_done;

    // Sequencer: state and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_total <= '0;
            r_ovf   <= 1'b0;
            r_ov    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= finish;
            // The output beat is held until the receiver takes it.
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (out_ch.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_idx  <= '0;
                    r_scan <= '0;
                    if (i_cmd_valid && !r_done) begin
                        if (i_cmd.is_report) begin
                            // An empty table goes straight to its single beat.
                            r_rank   <= '0;
                            r_have   <= 1'b0;
                            r_bfound <= 1'b0;
                            r_state  <= (r_used == '0) ? S_FETCH_W : S_SCAN;
                        end else begin
                            if (r_total != CountMax) begin
                                r_total <= r_total + 1'b1;
                            end
                            r_state <= (r_used == '0) ? S_SRCH_CHK : S_SRCH;
                        end
                    end
                end
                S_SRCH: begin
                    r_state <= S_SRCH_CHK;
                end
                S_SRCH_CHK: begin
                    if (at_end) begin
                        if (r_used == NW'(TABLE_ENTRIES)) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_used <= r_used + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end else if (hit) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_scan  <= r_scan + 1'b1;
                        r_idx   <= r_idx + 1'b1;
                        r_state <= (r_scan + 1'b1 == r_used) ? S_SRCH_CHK : S_SRCH;
                    end
                end
                S_SCAN: begin
                    r_state <= S_SCAN_CHK;
                end
                S_SCAN_CHK: begin
                    if (eligible && better) begin
                        r_bfound <= 1'b1;
                        r_bc     <= cd;
                        r_bi     <= r_idx;
                    end
                    if (r_scan + 1'b1 == r_used) begin
                        r_state <= S_FETCH;
                    end else begin
                        r_scan  <= r_scan + 1'b1;
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SCAN;
                    end
                end
                S_FETCH: begin
                    r_state <= S_FETCH_W;
                end
                S_FETCH_W: begin
                    // Load the output stage once it is free.
                    if (out_free) begin
                        r_oev    <= r_bfound;
                        r_orank  <= r_rank;
                        r_okey   <= r_bfound ? kd : '0;
                        r_ocnt   <= r_bfound ? cd : '0;
                        r_ototal <= r_total;
                        r_oovf   <= r_ovf;
                        r_olast  <= !r_bfound || (r_rank + 1'b1 == i_cmd.limit) ||
                                    (NW'(r_rank) + 1'b1 == r_used);
                        r_pc     <= r_bc;
                        r_pi     <= r_bi;
                        r_state  <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (r_olast) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_have   <= 1'b1;
                        r_rank   <= r_rank + 1'b1;
                        r_bfound <= 1'b0;
                        r_idx    <= '0;
                        r_scan   <= '0;
                        r_state  <= S_SCAN;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign out_ch.valid          = r_ov;
    assign out_ch.entry_valid    = r_oev;
    assign out_ch.rank           = r_orank;
    assign out_ch.entry_key_low  = r_okey[79:16];
    assign out_ch.entry_key_high = r_okey[15:0];
    assign out_ch.entry_count    = r_ocnt;
    assign out_ch.grand_total    = r_ototal;
    assign out_ch.table_overflow = r_oovf;
    assign out_ch.last           = r_olast;
endmodule
`default_nettype wire

// ----- rtl/core/keyed_occurrence_counter_top_k.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// keyed_occurrence_counter_top_k
// Frequency table of 10-character keys with a top-k report.
// ---------------------------------------------------------------------------
// A count beat searches the table serially, one used entry after another,
// through a single-port table RAM. A report rescans the table for each
// reported rank, and a rank waits while the receiver has not yet taken the
// previous beat. A two-deep command queue lets input beats be accepted
// while the back end works; results leave through a registered output stage.
module keyed_occurrence_counter_top_k #(
    parameter int TABLE_ENTRIES = 128,
    parameter int TOP_MAX       = 10
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    kocnt_in_if.sink    in_ch,
    kocnt_cfg_if.sink   cfg_ch,
    kocnt_out_if.source out_ch
);
    import kocnt_pkg::*;

    t_cmd cmd;
    logic cmd_valid;
    logic cmd_take;

    kocnt_front #(.TOP_MAX(TOP_MAX)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch), .cfg_ch(cfg_ch),
        .o_cmd(cmd), .o_cmd_valid(cmd_valid), .i_cmd_take(cmd_take));

    kocnt_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_cmd_valid(cmd_valid),
        .o_cmd_take(cmd_take), .out_ch(out_ch));
endmodule
`default_nettype wire
